@@ design/bfa_pkg.sv @@
// Shared constants, types and helpers for the bitmap frame allocator.
package bfa_pkg;

   localparam int BITMAP_WORDS = 1024;
   localparam int WORD_BITS    = 32;
   localparam int ADDR_W       = $clog2(BITMAP_WORDS);
   localparam int BIT_W        = $clog2(WORD_BITS);

   localparam int CMD_W        = 2;
   localparam int FRAME_W      = 15;
   localparam int COUNT_W      = 16;
   localparam int STATUS_W     = 2;
   localparam int PTR_W        = 16;
   localparam int WIU_W        = 11;
   localparam int WIDX_W       = PTR_W - BIT_W;
   localparam int RUN_W        = COUNT_W + 1;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [WIU_W-1:0] WIU_RESET = WIU_W'(1024);

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_MEM = 2'd1,
      STATUS_BAD    = 2'd2
   } status_type;

   typedef enum logic [CSR_ADDR_W-3:0] {
      REG_WORDS_IN_USE = 1'b0
   } reg_index_type;

   // n bits set starting at bit lo; n is 1..WORD_BITS and lo+n <= WORD_BITS
   function automatic logic [WORD_BITS-1:0] run_mask(input logic [BIT_W-1:0] lo,
                                                      input logic [BIT_W:0]   n);
      logic [WORD_BITS-1:0] ones;
      logic [BIT_W:0]       sh;
      ones = '1;
      sh   = (BIT_W+1)'(WORD_BITS) - n;
      return (ones >> sh) << lo;
   endfunction

endpackage

@@ design/bfa_csr.sv @@
// Configuration register block: words_in_use and its clamped form.
module bfa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bfa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bfa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bfa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output logic [bfa_pkg::WIU_W-1:0]       words_active
);

   logic [bfa_pkg::WIU_W-1:0] wiu_ff;
   logic [bfa_pkg::WIU_W-1:0] wiu_in;
   logic                      sel_wiu;

   assign csr_pready = 1'b1;
   assign sel_wiu    = csr_paddr[bfa_pkg::CSR_ADDR_W-1:2] == bfa_pkg::REG_WORDS_IN_USE;

   always_comb begin
      wiu_in = wiu_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_wiu) begin
         wiu_in = csr_pwdata[bfa_pkg::WIU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wiu_ff <= bfa_pkg::WIU_RESET;
      end else begin
         wiu_ff <= wiu_in;
      end
   end

   assign csr_prdata   = sel_wiu ? bfa_pkg::CSR_DATA_W'(wiu_ff) : '0;
   assign words_active = (32'(wiu_ff) > bfa_pkg::BITMAP_WORDS)
                         ? bfa_pkg::WIU_W'(bfa_pkg::BITMAP_WORDS) : wiu_ff;

endmodule

@@ design/bfa_engine.sv @@
// Bitmap memory with the sequencer for clearing, next-fit search and run marking.
module bfa_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bfa_pkg::WIU_W-1:0]     words_active,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bfa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bfa_pkg::FRAME_W-1:0]   req_start,
   input  logic [bfa_pkg::COUNT_W-1:0]   req_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bfa_pkg::FRAME_W-1:0]   rsp_frame
);

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_SCAN    = 6'b000100,
      ST_MARK_RD = 6'b001000,
      ST_MARK_WR = 6'b010000,
      ST_DONE    = 6'b100000
   } eng_state_type;

   logic [bfa_pkg::WORD_BITS-1:0] bitmap_mem [bfa_pkg::BITMAP_WORDS];
   logic [bfa_pkg::WORD_BITS-1:0] rd_data_ff;
   logic                          mem_rd_en;
   logic [bfa_pkg::ADDR_W-1:0]    mem_rd_addr;
   logic                          mem_wr_en;
   logic [bfa_pkg::ADDR_W-1:0]    mem_wr_addr;
   logic [bfa_pkg::WORD_BITS-1:0] mem_wr_data;

   eng_state_type                 state_ff, state_in;
   logic [bfa_pkg::ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [bfa_pkg::WIDX_W-1:0]    word_ff, word_in;
   logic [bfa_pkg::BIT_W-1:0]     bit_ff, bit_in;
   logic [bfa_pkg::RUN_W-1:0]     run_ff, run_in;
   logic [bfa_pkg::FRAME_W-1:0]   first_ff, first_in;
   logic [bfa_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          reserve_ff, reserve_in;
   logic [bfa_pkg::PTR_W-1:0]     cur_ff, cur_in;
   logic [bfa_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [bfa_pkg::PTR_W-1:0]     nsf_ff, nsf_in;
   logic [bfa_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [bfa_pkg::FRAME_W-1:0]   res_frame_ff, res_frame_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bfa_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [bfa_pkg::FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;

   logic [bfa_pkg::WIDX_W-1:0]    start_word;
   logic [bfa_pkg::WIDX_W-1:0]    word_next;
   logic                          range_bad;
   logic                          scan_hit;
   logic                          scan_next;
   logic [bfa_pkg::RUN_W-1:0]     run_now;
   logic [bfa_pkg::FRAME_W-1:0]   first_now;
   logic [bfa_pkg::FRAME_W-1:0]   bit_frame;
   logic [bfa_pkg::FRAME_W-1:0]   word_frame;
   logic [bfa_pkg::BIT_W:0]       mark_avail;
   logic [bfa_pkg::BIT_W:0]       mark_n;
   logic [bfa_pkg::WORD_BITS-1:0] mark_mask;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         bitmap_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= bitmap_mem[mem_rd_addr];
      end
   end

   assign start_word = nsf_ff[bfa_pkg::PTR_W-1:bfa_pkg::BIT_W];
   assign word_next  = word_ff + 1'b1;
   assign range_bad  = (bfa_pkg::RUN_W'(req_start) + bfa_pkg::RUN_W'(req_count))
                       > (bfa_pkg::RUN_W'(words_active) << bfa_pkg::BIT_W);
   assign bit_frame  = bfa_pkg::FRAME_W'({word_ff, bit_ff});
   assign word_frame = bfa_pkg::FRAME_W'({word_ff, bfa_pkg::BIT_W'(0)});

   // one word per cycle when full or empty, one bit per cycle otherwise
   always_comb begin
      scan_hit  = 1'b0;
      scan_next = 1'b0;
      run_now   = run_ff;
      first_now = first_ff;
      if (&rd_data_ff) begin
         run_now   = '0;
         scan_next = 1'b1;
      end else if (rd_data_ff == '0) begin
         first_now = (run_ff == '0) ? word_frame : first_ff;
         run_now   = run_ff + bfa_pkg::RUN_W'(bfa_pkg::WORD_BITS);
         scan_hit  = run_now >= bfa_pkg::RUN_W'(count_ff);
         scan_next = !scan_hit;
      end else begin
         if (!rd_data_ff[bit_ff]) begin
            first_now = (run_ff == '0) ? bit_frame : first_ff;
            run_now   = run_ff + 1'b1;
            scan_hit  = run_now >= bfa_pkg::RUN_W'(count_ff);
         end else begin
            run_now = '0;
         end
         scan_next = !scan_hit && (&bit_ff);
      end
   end

   assign mark_avail = (bfa_pkg::BIT_W+1)'(bfa_pkg::WORD_BITS)
                       - {1'b0, cur_ff[bfa_pkg::BIT_W-1:0]};
   assign mark_n     = (rem_ff < bfa_pkg::COUNT_W'(mark_avail))
                       ? (bfa_pkg::BIT_W+1)'(rem_ff) : mark_avail;
   assign mark_mask  = bfa_pkg::run_mask(cur_ff[bfa_pkg::BIT_W-1:0], mark_n);

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      word_in       = word_ff;
      bit_in        = bit_ff;
      run_in        = run_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      reserve_in    = reserve_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      nsf_in        = nsf_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = word_ff[bfa_pkg::ADDR_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = clr_cnt_ff;
      mem_wr_data   = '1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en  = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == bfa_pkg::ADDR_W'(bfa_pkg::BITMAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               count_in     = req_count;
               reserve_in   = req_cmd == bfa_pkg::CMD_RESERVE;
               res_frame_in = '0;
               if (req_count == '0 || req_cmd == bfa_pkg::CMD_UNUSED) begin
                  res_status_in = bfa_pkg::STATUS_BAD;
                  state_in      = ST_DONE;
               end else if (req_cmd == bfa_pkg::CMD_ALLOC) begin
                  word_in  = start_word;
                  bit_in   = nsf_ff[bfa_pkg::BIT_W-1:0];
                  run_in   = '0;
                  first_in = '0;
                  if (32'(start_word) >= 32'(words_active)) begin
                     res_status_in = bfa_pkg::STATUS_NO_MEM;
                     state_in      = ST_DONE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = start_word[bfa_pkg::ADDR_W-1:0];
                     state_in    = ST_SCAN;
                  end
               end else if (range_bad) begin
                  res_status_in = bfa_pkg::STATUS_BAD;
                  state_in      = ST_DONE;
               end else begin
                  cur_in        = bfa_pkg::PTR_W'(req_start);
                  rem_in        = req_count;
                  res_status_in = bfa_pkg::STATUS_OK;
                  state_in      = ST_MARK_RD;
               end
            end
         end
         ST_SCAN: begin
            run_in   = run_now;
            first_in = first_now;
            bit_in   = bit_ff + 1'b1;
            if (scan_hit) begin
               cur_in        = bfa_pkg::PTR_W'(first_now);
               rem_in        = count_ff;
               reserve_in    = 1'b1;
               nsf_in        = bfa_pkg::PTR_W'(first_now) + count_ff;
               res_status_in = bfa_pkg::STATUS_OK;
               res_frame_in  = first_now;
               state_in      = ST_MARK_RD;
            end else if (scan_next) begin
               word_in = word_next;
               bit_in  = '0;
               if (32'(word_next) >= 32'(words_active)) begin
                  res_status_in = bfa_pkg::STATUS_NO_MEM;
                  res_frame_in  = '0;
                  state_in      = ST_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = word_next[bfa_pkg::ADDR_W-1:0];
               end
            end
         end
         ST_MARK_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cur_ff[bfa_pkg::BIT_W +: bfa_pkg::ADDR_W];
            state_in    = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_ff[bfa_pkg::BIT_W +: bfa_pkg::ADDR_W];
            mem_wr_data = reserve_ff ? (rd_data_ff | mark_mask) : (rd_data_ff & ~mark_mask);
            cur_in      = cur_ff + bfa_pkg::PTR_W'(mark_n);
            rem_in      = rem_ff - bfa_pkg::COUNT_W'(mark_n);
            state_in    = (rem_ff == bfa_pkg::COUNT_W'(mark_n)) ? ST_DONE : ST_MARK_RD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_frame_in  = res_frame_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         nsf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         nsf_ff       <= nsf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      bit_ff        <= bit_in;
      run_ff        <= run_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      reserve_ff    <= reserve_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
   end

   assign req_ready  = state_ff == ST_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_frame  = rsp_frame_ff;

   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_CLEAR)
      |-> $past(clr_cnt_ff) == bfa_pkg::ADDR_W'(bfa_pkg::BITMAP_WORDS - 1))
      else $error("clearing pass left early");

   a_scan_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> run_ff < bfa_pkg::RUN_W'(count_ff))
      else $error("scan carries a run that already fits");

   a_mark_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK_WR |-> rem_ff != '0)
      else $error("marking with nothing left");

   a_ptr_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_RD && $past(state_ff) == ST_SCAN)
      |-> nsf_ff == cur_ff + bfa_pkg::PTR_W'(rem_ff))
      else $error("search pointer not moved past the allocated run");

endmodule

@@ design/bitmap_frame_allocator.sv @@
// Top level of the bitmap frame allocator.
// One bit per 4 KiB frame (1 reserved, 0 free) is held in a 1024 x 32 bit memory; after
// reset a clearing pass marks every frame reserved and req_tready stays low meanwhile.
// A transaction allocates a contiguous run by next-fit search (from the frame after the
// last allocation, no wrap), frees a run or reserves a run, and returns one result. Work
// is done on the bitmap memory one word at a time: an allocation visits fully reserved or
// fully free words whole and examines a partly free word bit by bit, then marks the run
// by a read-modify-write of each bitmap word it touches; free and reserve do the same
// read-modify-write per word touched; rejected requests go straight to the result. One
// request is worked on at a time; the next is taken while a result waits.
module bitmap_frame_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,   // start_frame[14:0], frame_count[30:15]
   input  logic [1:0]                     req_tuser,   // cmd[1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [15:0]                    rsp_tdata,   // alloc_frame_index[14:0]
   output logic [1:0]                     rsp_tuser,   // status[1:0]
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bfa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bfa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bfa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [bfa_pkg::WIU_W-1:0]    words_active;
   logic [bfa_pkg::FRAME_W-1:0]  rsp_frame;

   bfa_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .words_active (words_active)
   );

   bfa_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .words_active (words_active),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_cmd      (req_tuser),
      .req_start    (req_tdata[14:0]),
      .req_count    (req_tdata[30:15]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_status   (rsp_tuser),
      .rsp_frame    (rsp_frame)
   );

   assign rsp_tdata = {1'b0, rsp_frame};

endmodule
